### sv/rucef_pkg.sv
// ----------------------------------------------------------------------------
// rucef_pkg
// Shared types and constants for the unit-cube exit wall finder.
// ----------------------------------------------------------------------------
package rucef_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned DistW  = 32;
  localparam int unsigned TolW   = 16;

  localparam logic [TolW-1:0] TolReset = 16'd66;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [1:0] {
    MAT_GREY  = 2'd0,
    MAT_LEFT  = 2'd1,
    MAT_RIGHT = 2'd2
  } mat_e;

  // Per-axis lane result: wall test outcome, distance and saturated hit point
  typedef struct packed {
    logic                        ok;
    logic [DistW-1:0]            hit_dist;
    logic [2:0][CoordW-1:0]      h;
  } lane_res_t;

endpackage

### sv/rucef_lane.sv
// ----------------------------------------------------------------------------
// rucef_lane
// One wall candidate: plane distance, hit coordinates and edge test, 4 stages.
// ----------------------------------------------------------------------------
module rucef_lane #(
  parameter int unsigned Axis = 0
) (
  input  logic                                  clk_i,
  input  logic [2:0][rucef_pkg::CoordW-1:0]     pos_i,
  input  logic [2:0][rucef_pkg::CoordW-1:0]     dir_i,
  input  logic [rucef_pkg::CoordW-1:0]          inv_i,
  input  logic                                  neg_i,
  input  logic [rucef_pkg::TolW-1:0]            tol_i,
  output rucef_pkg::lane_res_t                  res_o
);

  // stage 1: n = floor((p + s) * inv / 2^16)
  logic signed [24:0] a;
  logic signed [48:0] m;
  logic signed [32:0] n_d, n_q;
  logic [2:0][23:0]   pos1_q, dir1_q;

  always_comb begin
    a   = $signed({pos_i[Axis][23], pos_i[Axis]}) + (neg_i ? 25'sd65536 : -25'sd65536);
    m   = a * $signed(inv_i);
    n_d = m[48:16];
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    pos1_q <= pos_i;
    dir1_q <= dir_i;
  end

  // stage 2: scaled direction products, saturated distance
  logic signed [56:0] prod [3];
  logic signed [40:0] q_d [3];
  logic signed [40:0] q_q [3];
  logic signed [33:0] nneg;
  logic [31:0]        dist_d, dist2_q;
  logic [2:0][23:0]   pos2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = $signed(dir1_q[k]) * n_q;
      q_d[k]  = prod[k][56:16];
    end
    nneg = -(34'(n_q));
    if (nneg > 34'sd2147483647) begin
      dist_d = 32'h7FFF_FFFF;
    end else if (nneg < -34'sd2147483648) begin
      dist_d = 32'h8000_0000;
    end else begin
      dist_d = nneg[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      q_q[k] <= q_d[k];
    end
    pos2_q  <= pos1_q;
    dist2_q <= dist_d;
  end

  // stage 3: hit coordinates, magnitude and saturation
  logic signed [41:0] h [3];
  logic [41:0]        mag [3];
  logic [2:0]         big_d, big3_q;
  logic [19:0]        mag3_q [3];
  logic [2:0][23:0]   hs_d, hs3_q;
  logic [31:0]        dist3_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h[k]     = 42'($signed(pos2_q[k])) - 42'(q_q[k]);
      mag[k]   = h[k][41] ? 42'(-h[k]) : 42'(h[k]);
      big_d[k] = |mag[k][41:20];
      if (h[k] > 42'sd8388607) begin
        hs_d[k] = 24'h7F_FFFF;
      end else if (h[k] < -42'sd8388608) begin
        hs_d[k] = 24'h80_0000;
      end else begin
        hs_d[k] = h[k][23:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      mag3_q[k] <= mag[k][19:0];
    end
    big3_q  <= big_d;
    hs3_q   <= hs_d;
    dist3_q <= dist2_q;
  end

  // stage 4: square and compare against 1 + epsilon
  logic [32:0] lim;
  logic [39:0] sq [3];
  logic        ok_d;
  rucef_pkg::lane_res_t res_q;

  always_comb begin
    lim  = {17'd65536 + 17'(tol_i), 16'd0};
    ok_d = 1'b1;
    for (int k = 0; k < 3; k++) begin
      sq[k] = 40'(mag3_q[k]) * 40'(mag3_q[k]);
      if (k != Axis) begin
        ok_d = ok_d & ~big3_q[k] & (sq[k] <= {7'd0, lim});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.ok       <= ok_d;
    res_q.hit_dist <= dist3_q;
    res_q.h        <= hs3_q;
  end

  assign res_o = res_q;

endmodule

### sv/ray_unit_cube_exit_face.sv
// An item's result strobe (done_o) follows the lane stages and the output select register.
// Throughput: one item per cycle; busy_o is never raised, so start_i may be high every cycle.
// Depth is set by the 4-stage lane pipeline (two multiplies, subtract, square) plus the
// output select register. The receiver cannot stall: every result is shown for one cycle.
// Reset (rst_ni low, asynchronous) clears the valid pipeline and sets edge_tolerance to 66.
// ----------------------------------------------------------------------------
// ray_unit_cube_exit_face
// Finds the wall of the cube [-1,1]^3 through which a ray from inside leaves.
// ----------------------------------------------------------------------------
module ray_unit_cube_exit_face (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        edge_tolerance_we_i,
  input  logic [15:0] edge_tolerance_i,
  // item in
  input  logic        start_i,
  output logic        busy_o,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  input  logic signed [23:0] dir_x_i,
  input  logic signed [23:0] dir_y_i,
  input  logic signed [23:0] dir_z_i,
  input  logic signed [23:0] inv_x_i,
  input  logic signed [23:0] inv_y_i,
  input  logic signed [23:0] inv_z_i,
  input  logic [2:0]  sign_bits_i,
  // result out
  output logic        done_o,
  output logic        hit_o,
  output logic signed [31:0] hit_distance_o,
  output logic signed [23:0] hit_x_o,
  output logic signed [23:0] hit_y_o,
  output logic signed [23:0] hit_z_o,
  output logic [1:0]  normal_axis_o,
  output logic        normal_positive_o,
  output logic [1:0]  material_code_o
);

  // Fully pipelined, never stalls
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // Edge tolerance register; user writes it only while no item is in flight, not enforced
  logic [rucef_pkg::TolW-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= rucef_pkg::TolReset;
    end else if (edge_tolerance_we_i) begin
      tol_q <= edge_tolerance_i;
    end
  end

  // Valid bits alongside the lane stages
  logic [3:0] vld_q;
  logic       done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[2:0], accept};
      done_q <= vld_q[3];
    end
  end

  // Three lanes, one per candidate wall, all run in parallel
  logic [2:0][23:0] pos, dir, inv;
  rucef_pkg::lane_res_t res [3];

  assign pos = {pos_z_i, pos_y_i, pos_x_i};
  assign dir = {dir_z_i, dir_y_i, dir_x_i};
  assign inv = {inv_z_i, inv_y_i, inv_x_i};

  for (genvar g = 0; g < 3; g++) begin : g_lane
    rucef_lane #(
      .Axis (g)
    ) u_lane (
      .clk_i (clk_i),
      .pos_i (pos),
      .dir_i (dir),
      .inv_i (inv[g]),
      .neg_i (sign_bits_i[g]),
      .tol_i (tol_q),
      .res_o (res[g])
    );
  end

  // Sign bits travel with the item for the normal and material fields
  logic [3:0][2:0] sgn_q;

  always_ff @(posedge clk_i) begin
    sgn_q <= {sgn_q[2:0], sign_bits_i};
  end

  // Output select: first passing axis in x, y, z order; all zero on a miss
  logic        hit_q, npos_q;
  logic [31:0] dist_q;
  logic [2:0][23:0] hp_q;
  rucef_pkg::axis_e axis_q;
  rucef_pkg::mat_e  mat_q;

  always_ff @(posedge clk_i) begin
    if (res[0].ok) begin
      hit_q  <= 1'b1;
      dist_q <= res[0].hit_dist;
      hp_q   <= res[0].h;
      axis_q <= rucef_pkg::AXIS_X;
      npos_q <= sgn_q[3][0];
      mat_q  <= sgn_q[3][0] ? rucef_pkg::MAT_RIGHT : rucef_pkg::MAT_LEFT;
    end else if (res[1].ok) begin
      hit_q  <= 1'b1;
      dist_q <= res[1].hit_dist;
      hp_q   <= res[1].h;
      axis_q <= rucef_pkg::AXIS_Y;
      npos_q <= sgn_q[3][1];
      mat_q  <= rucef_pkg::MAT_GREY;
    end else if (res[2].ok) begin
      hit_q  <= 1'b1;
      dist_q <= res[2].hit_dist;
      hp_q   <= res[2].h;
      axis_q <= rucef_pkg::AXIS_Z;
      npos_q <= sgn_q[3][2];
      mat_q  <= rucef_pkg::MAT_GREY;
    end else begin
      hit_q  <= 1'b0;
      dist_q <= '0;
      hp_q   <= '0;
      axis_q <= rucef_pkg::AXIS_X;
      npos_q <= 1'b0;
      mat_q  <= rucef_pkg::MAT_GREY;
    end
  end

  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign hit_distance_o    = dist_q;
  assign hit_x_o           = hp_q[0];
  assign hit_y_o           = hp_q[1];
  assign hit_z_o           = hp_q[2];
  assign normal_axis_o     = axis_q;
  assign normal_positive_o = npos_q;
  assign material_code_o   = mat_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##5 done_o)
    else $error("item did not come out after 5 cycles");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> hit_distance_o == '0 && hit_x_o == '0 && hit_y_o == '0 &&
                         hit_z_o == '0 && normal_axis_o == rucef_pkg::AXIS_X &&
                         !normal_positive_o && material_code_o == rucef_pkg::MAT_GREY)
    else $error("miss result carries non-zero fields");

  a_axis_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> normal_axis_o == rucef_pkg::AXIS_X || normal_axis_o == rucef_pkg::AXIS_Y ||
               normal_axis_o == rucef_pkg::AXIS_Z)
    else $error("bad normal axis");

  a_mat_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o && normal_axis_o == rucef_pkg::AXIS_X |->
      material_code_o == (normal_positive_o ? rucef_pkg::MAT_RIGHT : rucef_pkg::MAT_LEFT))
    else $error("x wall material does not match side");

  a_mat_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && normal_axis_o != rucef_pkg::AXIS_X |-> material_code_o == rucef_pkg::MAT_GREY)
    else $error("y or z wall not grey");
`endif

endmodule
